### src/lbrc_pkg.sv
// Package for the LDAP BindResponse checker.
// Holds the parse phase and verdict types, the BER tag constants and the
// long-form length helper; no dependencies.
package lbrc_pkg;

  localparam logic [7:0] TagSequence   = 8'h30;
  localparam logic [7:0] TagBindResp   = 8'h61;
  localparam logic [7:0] TagInteger    = 8'h02;
  localparam logic [7:0] TagEnumerated = 8'h0A;
  localparam logic [7:0] LenLongForm   = 8'h80;
  localparam logic [7:0] LenCountMask  = 8'h7F;

  localparam int unsigned CodeWidth = 32;
  localparam int unsigned LenWidth  = 24;

  typedef enum logic [3:0] {
    PH_SEQ_TAG,
    PH_SEQ_LEN,
    PH_SEQ_EXT,
    PH_MID_TAG,
    PH_MID_LEN,
    PH_MID_EXT,
    PH_MID_VAL,
    PH_RSP_TAG,
    PH_RSP_LEN,
    PH_RSP_EXT,
    PH_RC_TAG,
    PH_RC_LEN,
    PH_RC_EXT,
    PH_RC_VAL,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    VERDICT_SUCCESS,
    VERDICT_REFUSED,
    VERDICT_MALFORMED
  } verdict_e;

  typedef struct packed {
    logic                 valid;
    verdict_e             verdict;
    logic [CodeWidth-1:0] code;
  } result_t;

  // Number of further length bytes after a long-form lead byte; zero for
  // the indefinite form and for lengths of more than three bytes.
  function automatic logic [1:0] long_count(logic [7:0] b);
    logic [7:0] n;
    n = b & LenCountMask;
    if (b > LenLongForm && n < 8'd4) begin
      return n[1:0];
    end
    return 2'd0;
  endfunction

endpackage

### src/lbrc_parser.sv
// Byte-wise BER parse state machine of the LDAP BindResponse checker.
// Advances one byte per accepted transaction and flags the verdict.
// Depends on lbrc_pkg.
module lbrc_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output lbrc_pkg::result_t result_o
);
  import lbrc_pkg::*;

  phase_e                phase_q, phase_d;
  logic [1:0]            ext_q, ext_d;
  logic [LenWidth-1:0]   len_q, len_d;
  logic [CodeWidth-1:0]  code_q, code_d;

  logic [1:0]            ext_dec;
  logic [LenWidth-1:0]   len_shift;
  logic [LenWidth-1:0]   len_dec;
  logic [CodeWidth-1:0]  code_shift;
  logic [1:0]            lc;
  result_t               res;

  assign ext_dec    = ext_q - 2'd1;
  assign len_shift  = {len_q[LenWidth-9:0], byte_i};
  assign len_dec    = len_q - LenWidth'(1);
  assign code_shift = {code_q[CodeWidth-9:0], byte_i};
  assign lc         = long_count(byte_i);

  always_comb begin
    phase_d     = phase_q;
    ext_d       = ext_q;
    len_d       = len_q;
    code_d      = code_q;
    res.valid   = 1'b0;
    res.verdict = VERDICT_MALFORMED;
    res.code    = '0;

    case (phase_q)
      PH_SEQ_TAG: begin
        if (byte_i != TagSequence) begin
          res.valid = 1'b1;
        end else begin
          phase_d = PH_SEQ_LEN;
        end
      end
      PH_SEQ_LEN: begin
        if (byte_i < LenLongForm) begin
          if (byte_i == 8'd0) begin
            res.valid = 1'b1;
          end else begin
            phase_d = PH_MID_TAG;
          end
        end else if (lc == 2'd0) begin
          res.valid = 1'b1;
        end else begin
          ext_d   = lc;
          len_d   = '0;
          phase_d = PH_SEQ_EXT;
        end
      end
      PH_SEQ_EXT: begin
        ext_d = ext_dec;
        len_d = len_shift;
        if (ext_dec == 2'd0) begin
          if (len_shift == '0) begin
            res.valid = 1'b1;
          end else begin
            phase_d = PH_MID_TAG;
          end
        end
      end
      PH_MID_TAG, PH_RSP_TAG: begin
        if (phase_q == PH_MID_TAG && byte_i == TagInteger) begin
          phase_d = PH_MID_LEN;
        end else if (byte_i != TagBindResp) begin
          res.valid = 1'b1;
        end else begin
          phase_d = PH_RSP_LEN;
        end
      end
      PH_MID_LEN: begin
        if (byte_i < LenLongForm) begin
          len_d   = LenWidth'(byte_i);
          phase_d = (byte_i == 8'd0) ? PH_RSP_TAG : PH_MID_VAL;
        end else if (lc == 2'd0) begin
          phase_d = PH_RSP_TAG;
        end else begin
          ext_d   = lc;
          len_d   = '0;
          phase_d = PH_MID_EXT;
        end
      end
      PH_MID_EXT: begin
        ext_d = ext_dec;
        len_d = len_shift;
        if (ext_dec == 2'd0) begin
          phase_d = (len_shift == '0) ? PH_RSP_TAG : PH_MID_VAL;
        end
      end
      PH_MID_VAL: begin
        len_d = len_dec;
        if (len_dec == '0) begin
          phase_d = PH_RSP_TAG;
        end
      end
      PH_RSP_LEN: begin
        if (lc == 2'd0) begin
          phase_d = PH_RC_TAG;
        end else begin
          ext_d   = lc;
          len_d   = '0;
          phase_d = PH_RSP_EXT;
        end
      end
      PH_RSP_EXT: begin
        ext_d = ext_dec;
        len_d = len_shift;
        if (ext_dec == 2'd0) begin
          phase_d = PH_RC_TAG;
        end
      end
      PH_RC_TAG: begin
        if (byte_i != TagEnumerated) begin
          res.valid = 1'b1;
        end else begin
          phase_d = PH_RC_LEN;
        end
      end
      PH_RC_LEN: begin
        code_d = '0;
        if (byte_i < LenLongForm) begin
          if (byte_i == 8'd0) begin
            res.valid = 1'b1;
          end else begin
            len_d   = LenWidth'(byte_i);
            phase_d = PH_RC_VAL;
          end
        end else if (lc == 2'd0) begin
          res.valid = 1'b1;
        end else begin
          ext_d   = lc;
          len_d   = '0;
          phase_d = PH_RC_EXT;
        end
      end
      PH_RC_EXT: begin
        ext_d = ext_dec;
        len_d = len_shift;
        if (ext_dec == 2'd0) begin
          if (len_shift == '0) begin
            res.valid = 1'b1;
          end else begin
            phase_d = PH_RC_VAL;
          end
        end
      end
      PH_RC_VAL: begin
        code_d = code_shift;
        len_d  = len_dec;
        if (len_dec == '0) begin
          res.valid   = 1'b1;
          res.verdict = (code_shift == '0) ? VERDICT_SUCCESS : VERDICT_REFUSED;
          res.code    = code_shift;
        end
      end
      default: begin
      end
    endcase

    if (res.valid) begin
      phase_d = PH_DONE;
    end

    // A message that ends before its verdict is truncated.
    if (last_i && !res.valid && phase_q != PH_DONE) begin
      res.valid   = 1'b1;
      res.verdict = VERDICT_MALFORMED;
      res.code    = '0;
    end

    if (last_i) begin
      phase_d = PH_SEQ_TAG;
      ext_d   = '0;
      len_d   = '0;
      code_d  = '0;
    end

    res.valid = res.valid & step_i;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEQ_TAG;
      ext_q   <= '0;
      len_q   <= '0;
      code_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ext_q   <= ext_d;
      len_q   <= len_d;
      code_q  <= code_d;
    end
  end

endmodule

### src/lbrc_out_reg.sv
// Output register of the LDAP BindResponse checker.
// Holds one verdict until the receiver takes it; depends on lbrc_pkg.
module lbrc_out_reg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lbrc_pkg::result_t              result_i,
  output logic                           ready_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  output lbrc_pkg::verdict_e             verdict_o,
  output logic [lbrc_pkg::CodeWidth-1:0] code_o
);
  import lbrc_pkg::*;

  logic                 valid_q, valid_d;
  verdict_e             verdict_q;
  logic [CodeWidth-1:0] code_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (result_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      verdict_q <= result_i.verdict;
      code_q    <= result_i.code;
    end
  end

  assign valid_o   = valid_q;
  assign verdict_o = verdict_q;
  assign code_o    = code_q;

endmodule

### src/ldap_bind_response_checker.sv
// Top level of the LDAP BindResponse checker.
// Instantiates lbrc_parser and lbrc_out_reg; depends on lbrc_pkg.
//
// Message bytes enter on the slave stream, one byte per transaction, with
// tlast on the final byte of each message. The block checks the BER layout
// of an LDAP BindResponse and gives one verdict transaction per message on
// the master stream: tuser carries the verdict (success, refused or
// malformed) and tdata the low 32 bits of the resultCode, zero when the
// message is malformed.
// The registered verdict appears in the cycle after the byte settling it is taken.
// A byte can be accepted in every cycle unless the output register is full
// and the receiver stalls; the one-byte state machine is the only loop.
// Bytes after the verdict are consumed without output up to and including
// tlast, and a message that ends early gives malformed on its last byte.
// The single output register holds a verdict while the receiver stalls;
// tready on the slave side is low only while that register is full and the
// receiver is not taking it. Reset returns the parser to await the outer
// SEQUENCE tag and empties the output register.
module ldap_bind_response_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] status_code
  output logic [1:0]  m_axis_tuser_o    // [1:0] verdict
);
  import lbrc_pkg::*;

  logic     step;
  result_t  result;
  verdict_e verdict;

  assign step = s_axis_tvalid_i && s_axis_tready_o;

  lbrc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .result_o (result)
  );

  lbrc_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .result_i  (result),
    .ready_o   (s_axis_tready_o),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .verdict_o (verdict),
    .code_o    (m_axis_tdata_o)
  );

  assign m_axis_tuser_o = verdict;

endmodule
